/* src/aigsim_pkg.sv */
// shared types, constants and controller commands for the aig simulation core
package aigsim_pkg;

  localparam int MAX_NODES    = 4096;
  localparam int PATTERN_BITS = 64;
  localparam int IDX_W        = $clog2(MAX_NODES);
  localparam int CNT_W        = $clog2(MAX_NODES + 1);
  localparam int SIZE_W       = 13;

  localparam logic [SIZE_W-1:0] SIZE_SAT = {SIZE_W{1'b1}};
  localparam logic [CNT_W-1:0]  CNT_FULL = CNT_W'(MAX_NODES);

  typedef enum logic [1:0] {
    REQ_CONST  = 2'd0,
    REQ_INPUT  = 2'd1,
    REQ_AND    = 2'd2,
    REQ_REPORT = 2'd3
  } req_type_t;

  typedef struct packed {
    req_type_t         req_type;
    logic [11:0]       node_index;
    logic [11:0]       first_fanin;
    logic [11:0]       second_fanin;
    logic              first_inverted;
    logic              second_inverted;
    logic [63:0]       random_pattern;
  } in_word_t;

  typedef struct packed {
    logic [63:0]       sim_pattern;
    logic [11:0]       class_slot;
    logic              opened_class;
    logic [12:0]       nontrivial_classes;
    logic [12:0]       class_total;
    logic [12:0]       members_in_nontrivial;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_A,
    ST_RD_B,
    ST_RD_WAIT,
    ST_PWRITE,
    ST_SCAN,
    ST_HIT,
    ST_MISS,
    ST_REP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic latch;
    logic rd_second;
    logic capture_a;
    logic compute;
    logic pat_write;
    logic scan_start;
    logic scan_run;
    logic hit_capture;
    logic hit_write;
    logic open_class;
    logic rep_acc;
  } dp_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic match;
    logic last;
  } dp_status_t;

endpackage

/* src/aigsim_ram.sv */
// generic single-write, single-read ram with registered read data
module aigsim_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/aigsim_ctrl.sv */
// controller state machine sequencing simulation, class search and report
module aigsim_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  aigsim_pkg::req_type_t   req_type,
  input  aigsim_pkg::dp_status_t  status,
  output aigsim_pkg::dp_cmd_t     cmd,
  output logic                    busy,
  output logic                    out_valid
);
  import aigsim_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (req_type)
            REQ_AND:    state_nxt = ST_RD_A;
            REQ_REPORT: state_nxt = status.count_zero ? ST_DONE : ST_REP;
            default:    state_nxt = ST_PWRITE;
          endcase
        end
      end
      ST_RD_A:    state_nxt = ST_RD_B;
      ST_RD_B:    state_nxt = ST_RD_WAIT;
      ST_RD_WAIT: state_nxt = ST_PWRITE;
      ST_PWRITE:  state_nxt = status.count_zero ? ST_MISS : ST_SCAN;
      ST_SCAN: begin
        if (status.match) begin
          state_nxt = ST_HIT;
        end else if (status.last) begin
          state_nxt = ST_MISS;
        end
      end
      ST_HIT:  state_nxt = ST_DONE;
      ST_MISS: state_nxt = ST_DONE;
      ST_REP: begin
        if (status.last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    busy      = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        busy           = 1'b0;
        cmd.latch      = start;
        cmd.scan_start = start;
      end
      ST_RD_A: cmd.rd_second = 1'b0;
      ST_RD_B: begin
        cmd.rd_second = 1'b1;
        cmd.capture_a = 1'b1;
      end
      ST_RD_WAIT: cmd.compute = 1'b1;
      ST_PWRITE: begin
        cmd.pat_write  = 1'b1;
        cmd.scan_start = 1'b1;
      end
      ST_SCAN: begin
        cmd.scan_run    = 1'b1;
        cmd.hit_capture = status.match;
      end
      ST_HIT:  cmd.hit_write  = 1'b1;
      ST_MISS: cmd.open_class = 1'b1;
      ST_REP: begin
        cmd.scan_run = 1'b1;
        cmd.rep_acc  = 1'b1;
      end
      ST_DONE: out_valid = 1'b1;
      default: busy = 1'b1;
    endcase
  end

endmodule

/* src/aigsim_dp.sv */
// datapath: pattern store, class signature and size stores, scan pipeline
module aigsim_dp (
  input  logic                    clk,
  input  logic                    rst_n,
  input  aigsim_pkg::in_word_t    in_word,
  input  aigsim_pkg::dp_cmd_t     cmd,
  output aigsim_pkg::dp_status_t  status,
  output aigsim_pkg::out_word_t   out_word
);
  import aigsim_pkg::*;

  in_word_t                in_r;
  logic [PATTERN_BITS-1:0] pat_r, a_r;
  logic [CNT_W-1:0]        count_r;
  logic [CNT_W-1:0]        issue_r;
  logic [CNT_W-1:0]        cmp_idx_r;
  logic                    cmp_valid_r;
  logic [IDX_W-1:0]        slot_r;
  logic                    opened_r;
  logic [SIZE_W-1:0]       hit_size_r;
  logic [CNT_W-1:0]        nontriv_r;
  logic [SIZE_W-1:0]       members_r;

  logic [PATTERN_BITS-1:0] pat_rdata, sig_rdata, b_val, a_val;
  logic [SIZE_W-1:0]       size_rdata, size_wdata;
  logic [IDX_W-1:0]        pat_raddr, size_waddr;
  logic                    open_do, size_we, issue_ok;

  assign pat_raddr  = cmd.rd_second ? in_r.second_fanin[IDX_W-1:0]
                                    : in_r.first_fanin[IDX_W-1:0];
  assign open_do    = cmd.open_class && (count_r != CNT_FULL);
  assign size_we    = cmd.hit_write || open_do;
  assign size_waddr = cmd.hit_write ? slot_r : count_r[IDX_W-1:0];
  assign size_wdata = cmd.hit_write ? hit_size_r : SIZE_W'(1);
  assign issue_ok   = cmd.scan_run && (issue_r < count_r);

  assign a_val = in_r.first_inverted  ? ~a_r       : a_r;
  assign b_val = in_r.second_inverted ? ~pat_rdata : pat_rdata;

  aigsim_ram #(.WIDTH(PATTERN_BITS), .DEPTH(MAX_NODES)) u_pat_ram (
    .clk   (clk),
    .we    (cmd.pat_write),
    .waddr (in_r.node_index[IDX_W-1:0]),
    .wdata (pat_r),
    .raddr (pat_raddr),
    .rdata (pat_rdata)
  );

  aigsim_ram #(.WIDTH(PATTERN_BITS), .DEPTH(MAX_NODES)) u_sig_ram (
    .clk   (clk),
    .we    (open_do),
    .waddr (count_r[IDX_W-1:0]),
    .wdata (pat_r),
    .raddr (issue_r[IDX_W-1:0]),
    .rdata (sig_rdata)
  );

  aigsim_ram #(.WIDTH(SIZE_W), .DEPTH(MAX_NODES)) u_size_ram (
    .clk   (clk),
    .we    (size_we),
    .waddr (size_waddr),
    .wdata (size_wdata),
    .raddr (issue_r[IDX_W-1:0]),
    .rdata (size_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      cmp_valid_r <= 1'b0;
    end else begin
      if (open_do) begin
        count_r <= count_r + CNT_W'(1);
      end
      cmp_valid_r <= issue_ok;
    end
  end

  // payload and scan registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      in_r      <= in_word;
      slot_r    <= '0;
      opened_r  <= 1'b0;
      nontriv_r <= '0;
      members_r <= '0;
      case (in_word.req_type)
        REQ_CONST: pat_r <= '1;
        REQ_INPUT: pat_r <= in_word.random_pattern[PATTERN_BITS-1:0];
        default:   pat_r <= '0;
      endcase
    end
    if (cmd.capture_a) begin
      a_r <= pat_rdata;
    end
    if (cmd.compute) begin
      pat_r <= a_val & b_val;
    end
    if (cmd.scan_start) begin
      issue_r <= '0;
    end else if (issue_ok) begin
      issue_r <= issue_r + CNT_W'(1);
    end
    cmp_idx_r <= issue_r;
    if (cmd.hit_capture) begin
      slot_r     <= cmp_idx_r[IDX_W-1:0];
      hit_size_r <= (size_rdata == SIZE_SAT) ? size_rdata : size_rdata + SIZE_W'(1);
    end
    if (open_do) begin
      slot_r   <= count_r[IDX_W-1:0];
      opened_r <= 1'b1;
    end
    if (cmd.rep_acc && cmp_valid_r && (size_rdata > SIZE_W'(1))) begin
      nontriv_r <= nontriv_r + CNT_W'(1);
      members_r <= members_r + size_rdata;
    end
  end

  assign status.count_zero = (count_r == '0);
  assign status.match      = cmp_valid_r && (sig_rdata == pat_r);
  assign status.last       = cmp_valid_r && (cmp_idx_r == count_r - CNT_W'(1));

  assign out_word.sim_pattern           = 64'(pat_r);
  assign out_word.class_slot            = 12'(slot_r);
  assign out_word.opened_class          = opened_r;
  assign out_word.nontrivial_classes    = 13'(nontriv_r);
  assign out_word.class_total           = 13'(count_r);
  assign out_word.members_in_nontrivial = 13'(members_r);

endmodule

/* src/aig_simulate_and_signature_classes_core.sv */
// top level of the and-inverter graph simulation and signature class core
//
// Objects of the graph arrive one word at a time on in_word, in topological
// order. A word is taken at a rising edge where start is high and busy is
// low; busy stays high until its result has been shown.
// Each word gives exactly one result word on out_word, marked by out_valid
// for a single cycle; the receiver must take it then, it cannot stall.
// Steps from accept to out_valid:
//   constant or primary input : pattern write, then the class search
//   and node                  : two fanin reads, the and, pattern write,
//                               then the class search
//   class search              : none while no class is open, ends early on a hit
//   report                    : scans every open class, none if no class is open
// busy drops the cycle after out_valid, so the next word can be taken right
// after the result. The class search reads one stored signature per cycle
// from the signature memory, and an and node reads its two fanins one after
// the other through the pattern store's single read port.
// Reset clears the class count and the controller; the memories need no
// clearing, since only written entries are ever read.
module aig_simulate_and_signature_classes_core (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  aigsim_pkg::in_word_t   in_word,
  output logic                   out_valid,
  output aigsim_pkg::out_word_t  out_word
);
  import aigsim_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  aigsim_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .req_type  (in_word.req_type),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  aigsim_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_word),
    .cmd      (cmd),
    .status   (status),
    .out_word (out_word)
  );

`ifndef SYNTHESIS
  a_idle_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy)
    else $error("block still busy after its result word");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not make the block busy");

  a_total_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word.class_total <= 13'(MAX_NODES)))
    else $error("class total beyond class store depth");

  a_open_is_newest: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.opened_class) |->
      (out_word.class_total == {1'b0, out_word.class_slot} + 13'd1))
    else $error("opened class is not the newest slot");
`endif

endmodule
